/* src/ponte_pkg.sv */
// Package for the pitch onset note trigger: payload types, codes, note table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ponte_pkg;
   typedef enum logic [1:0] {EV_NONE = 2'd0, EV_NOTE_ON = 2'd1, EV_NOTE_OFF = 2'd2} event_type;
   typedef enum logic [2:0] {
      CSR_ONSET = 3'd0, CSR_QUIET = 3'd1, CSR_CONF_HI = 3'd2, CSR_CONF_LO = 3'd3,
      CSR_SPLIT = 3'd4, CSR_CAPTURE = 3'd5, CSR_RELEASE = 3'd6, CSR_GAIN = 3'd7
   } csr_index_type;

   localparam int BOUND_COUNT = 59;
   localparam logic [15:0] PITCH_MIN = 16'd320;
   localparam logic [15:0] PITCH_MAX = 16'd9600;
   localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
   localparam logic [6:0] NOTE_BASE = 7'd16;

   typedef struct packed {
      logic        peak_valid;
      logic [15:0] peak_value;
      logic        pitch_valid;
      logic [15:0] pitch_value;
      logic [10:0] confidence_value;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic        note_active;
   } rsp_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic        note_on;     // needs mean and note search
      logic [23:0] sum;
      logic [15:0] count;
      logic [6:0]  velocity;
      logic [1:0]  event_res;
      logic        note_active;
   } job_type;

   function automatic logic [13:0] bound(input logic [5:0] i);
      logic [13:0] t [0:58];
      t = '{14'd340, 14'd360, 14'd381, 14'd404, 14'd428, 14'd453, 14'd480, 14'd509,
            14'd539, 14'd571, 14'd605, 14'd641, 14'd679, 14'd719, 14'd762, 14'd807,
            14'd855, 14'd906, 14'd960, 14'd1017, 14'd1078, 14'd1142, 14'd1210,
            14'd1281, 14'd1358, 14'd1438, 14'd1524, 14'd1614, 14'd1710, 14'd1812,
            14'd1920, 14'd2034, 14'd2155, 14'd2283, 14'd2419, 14'd2562, 14'd2715,
            14'd2876, 14'd3047, 14'd3228, 14'd3420, 14'd3624, 14'd3839, 14'd4067,
            14'd4309, 14'd4565, 14'd4837, 14'd5124, 14'd5429, 14'd5752, 14'd6094,
            14'd6456, 14'd6840, 14'd7247, 14'd7678, 14'd8134, 14'd8618, 14'd9130,
            14'd9673};
      if (i < 6'd59) begin
         return t[i];
      end
      return 14'h3FFF;
   endfunction
endpackage
`default_nettype wire

/* src/ponte_front.sv */
// Front part: holds readings, tracks onset, capture and release, builds jobs.
// Depends on ponte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ponte_front
   import ponte_pkg::*;
#(
   parameter int COUNT_MAX = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire req_type     in_item,
   output logic             job_valid,
   input  wire logic        job_ready,
   output job_type          job_data
);
   localparam int CW = $clog2(COUNT_MAX + 1);

   logic [15:0] onset_ff, quiet_ff, split_ff, capt_ff, rel_ff;
   logic [10:0] chi_ff, clo_ff;
   logic [11:0] gain_ff;
   logic [15:0] hpeak_ff, hpitch_ff, prev_ff, opeak_ff;
   logic [10:0] hconf_ff;
   logic        capt_on_ff, sound_ff;
   logic [31:0] wstart_ff, loud_ff;
   logic [23:0] sum_ff;
   logic [CW-1:0] cnt_ff;
   logic        jv_ff;
   job_type     job_ff;
   logic        busy_ff;

   // combinational tick evaluation
   logic [15:0] pk, pt, pk_r;
   logic [10:0] cf, thr;
   logic        snd1, onset, cap1, acc, close1, snd2, off;
   logic [31:0] loud1, ws1;
   logic [24:0] sadd;
   logic [23:0] sum1, sum2;
   logic [CW-1:0] cnt1, cnt2;
   logic [27:0] vprod;
   logic [11:0] vraw;
   logic [6:0]  vel;
   job_type     job_in;

   assign in_ready = !busy_ff && !jv_ff;

   always_comb begin
      pk = in_item.peak_valid ? in_item.peak_value : hpeak_ff;
      pt = in_item.pitch_valid ? in_item.pitch_value : hpitch_ff;
      cf = in_item.pitch_valid ? in_item.confidence_value : hconf_ff;
      loud1 = (sound_ff && pk > quiet_ff) ? in_item.now_ms : loud_ff;
      onset = !sound_ff && !capt_on_ff && pk > onset_ff && prev_ff <= onset_ff;
      cap1 = capt_on_ff || onset;
      ws1 = onset ? in_item.now_ms : wstart_ff;
      pk_r = onset ? pk : opeak_ff;
      sum1 = onset ? 24'd0 : sum_ff;
      cnt1 = onset ? '0 : cnt_ff;
      thr = (pt < split_ff) ? clo_ff : chi_ff;
      acc = !sound_ff && cap1 && cf > thr && pt > PITCH_MIN && pt < PITCH_MAX &&
            cnt1 < CW'(COUNT_MAX);
      sadd = {1'b0, sum1} + {9'd0, pt};
      sum2 = acc ? (sadd[24] ? SUM_MAX : sadd[23:0]) : sum1;
      cnt2 = acc ? cnt1 + CW'(1) : cnt1;
      close1 = !sound_ff && cap1 && (in_item.now_ms - ws1) >= {16'd0, capt_ff};
      snd1 = sound_ff || (close1 && cnt2 >= CW'(2));
      if (close1 && cnt2 >= CW'(2)) begin
         loud1 = in_item.now_ms;
      end
      off = snd1 && (in_item.now_ms - loud1) > {16'd0, rel_ff};
      snd2 = snd1 && !off;
      vprod = pk_r * gain_ff;
      vraw = vprod[27:16];
      vel = (vraw < 12'd20) ? 7'd20 : (vraw > 12'd127) ? 7'd127 : vraw[6:0];
      job_in.note_on = close1 && cnt2 >= CW'(2) && !off;
      job_in.sum = sum2;
      job_in.count = 16'(cnt2);
      job_in.velocity = vel;
      job_in.event_res = off ? EV_NOTE_OFF : job_in.note_on ? EV_NOTE_ON : EV_NONE;
      job_in.note_active = snd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         onset_ff <= 16'd655; quiet_ff <= 16'd328; chi_ff <= 11'd717;
         clo_ff <= 11'd512; split_ff <= 16'd1440; capt_ff <= 16'd20;
         rel_ff <= 16'd150; gain_ff <= 12'd1200;
         hpeak_ff <= '0; hpitch_ff <= '0; hconf_ff <= '0; prev_ff <= '0;
         capt_on_ff <= 1'b0; wstart_ff <= '0; opeak_ff <= '0; sum_ff <= '0;
         cnt_ff <= '0; sound_ff <= 1'b0; loud_ff <= '0;
         jv_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ONSET:   onset_ff <= csr_data;
               CSR_QUIET:   quiet_ff <= csr_data;
               CSR_CONF_HI: chi_ff <= csr_data[10:0];
               CSR_CONF_LO: clo_ff <= csr_data[10:0];
               CSR_SPLIT:   split_ff <= csr_data;
               CSR_CAPTURE: capt_ff <= csr_data;
               CSR_RELEASE: rel_ff <= csr_data;
               CSR_GAIN:    gain_ff <= csr_data[11:0];
               default: ;
            endcase
         end
         busy_ff <= 1'b0;
         if (jv_ff && job_ready) begin
            jv_ff <= 1'b0;
         end
         if (in_valid && in_ready) begin
            hpeak_ff <= pk; hpitch_ff <= pt; hconf_ff <= cf; prev_ff <= pk;
            capt_on_ff <= cap1 && !close1;
            wstart_ff <= ws1; opeak_ff <= pk_r; sum_ff <= sum2; cnt_ff <= cnt2;
            sound_ff <= snd2; loud_ff <= loud1;
            jv_ff <= 1'b1;
            job_ff <= job_in;
         end
      end
   end

   assign job_valid = jv_ff;
   assign job_data = job_ff;
endmodule
`default_nettype wire

/* src/ponte_fifo.sv */
// Two-entry item queue between front and back parts.
// Depends on ponte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ponte_fifo
   import ponte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_data
);
   job_type    mem_ff [0:1];
   logic       wp_ff, rp_ff;
   logic [1:0] n_ff;
   logic       wr, rd;

   assign in_ready = n_ff != 2'd2;
   assign out_valid = n_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; n_ff <= 2'd0;
      end else begin
         if (wr) begin
            wp_ff <= !wp_ff;
         end
         if (rd) begin
            rp_ff <= !rp_ff;
         end
         n_ff <= n_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule
`default_nettype wire

/* src/ponte_back.sv */
// Back part: restoring divide for the mean, table walk for the note, output register.
// Depends on ponte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ponte_back
   import ponte_pkg::*;
#(
   parameter int NOTE_LOW  = 25,
   parameter int NOTE_HIGH = 108
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_SEARCH, S_OUT} state_type;
   state_type   state_ff;
   job_type     job_ff;
   logic [23:0] quo_ff;
   logic [16:0] rem_ff;
   logic [4:0]  step_ff;
   logic [5:0]  idx_ff;
   logic [6:0]  note_ff;
   rsp_type     rsp_ff;
   logic [16:0] trial;
   logic [6:0]  clamped;

   assign job_ready = state_ff == S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign out_data = rsp_ff;
   assign trial = {rem_ff[15:0], quo_ff[23]};

   always_comb begin
      clamped = note_ff;
      if (clamped < 7'(NOTE_LOW)) begin
         clamped = 7'(NOTE_LOW);
      end
      if (clamped > 7'(NOTE_HIGH)) begin
         clamped = 7'(NOTE_HIGH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  quo_ff <= job_data.sum;
                  rem_ff <= '0;
                  step_ff <= '0;
                  idx_ff <= '0;
                  note_ff <= NOTE_BASE;
                  if (job_data.note_on) begin
                     state_ff <= S_DIV;
                  end else begin
                     rsp_ff <= '{job_data.event_res, 7'd0, 7'd0, job_data.note_active};
                     state_ff <= S_OUT;
                  end
               end
            end
            S_DIV: begin
               if (trial >= {1'b0, job_ff.count}) begin
                  rem_ff <= trial - {1'b0, job_ff.count};
                  quo_ff <= {quo_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[22:0], 1'b0};
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd23) begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (idx_ff < 6'(BOUND_COUNT) && quo_ff >= {10'd0, bound(idx_ff)}) begin
                  note_ff <= note_ff + 7'd1;
                  idx_ff <= idx_ff + 6'd1;
               end else begin
                  rsp_ff <= '{job_ff.event_res, clamped, job_ff.velocity,
                              job_ff.note_active};
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* src/pitch_onset_note_trigger_unit.sv */
// Top level of the pitch onset note trigger: front, queue and back part.
// Depends on ponte_pkg, ponte_front, ponte_fifo, ponte_back.
// One result item per tick. A tick without a note-on passes the front register and
// the queue and goes straight to the back output register. A note-on passes the front
// register and the queue, the 24 steps of the bit-serial mean divider and a walk of
// the 59-entry note boundary table before its result is held for the handshake.
// A stalled rsp_tready holds the result in the back output register.
`timescale 1ns / 1ps
`default_nettype none
module pitch_onset_note_trigger_unit
   import ponte_pkg::*;
#(
   parameter int COUNT_MAX = 255,
   parameter int NOTE_LOW  = 25,
   parameter int NOTE_HIGH = 108
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // peak_valid, peak_value, pitch_valid, pitch_value, confidence_value, now_ms
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // event_res, note_number, velocity, note_active
   output logic [23:0]      rsp_tdata
);
   req_type in_item;
   job_type f_job, b_job;
   logic    fv, fr, bv, br;
   rsp_type rsp;

   assign in_item.peak_valid = req_tdata[0];
   assign in_item.peak_value = req_tdata[16:1];
   assign in_item.pitch_valid = req_tdata[17];
   assign in_item.pitch_value = req_tdata[33:18];
   assign in_item.confidence_value = req_tdata[44:34];
   assign in_item.now_ms = req_tdata[76:45];

   ponte_front #(.COUNT_MAX(COUNT_MAX)) u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .job_valid(fv), .job_ready(fr), .job_data(f_job));

   ponte_fifo u_fifo (
      .clock, .reset, .in_valid(fv), .in_ready(fr), .in_data(f_job),
      .out_valid(bv), .out_ready(br), .out_data(b_job));

   ponte_back #(.NOTE_LOW(NOTE_LOW), .NOTE_HIGH(NOTE_HIGH)) u_back (
      .clock, .reset, .job_valid(bv), .job_ready(br), .job_data(b_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp));

   assign rsp_tdata = {7'd0, rsp.note_active, rsp.velocity, rsp.note_number, rsp.event_res};
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for pitch_onset_note_trigger_unit: random and directed service ticks,
// results checked against an in-bench note trigger predictor. Depends on ponte_pkg.
`timescale 1ns / 1ps
module tb;
   import ponte_pkg::*;

   typedef struct {
      logic [1:0] ev;
      logic [6:0] note;
      logic [6:0] vel;
      logic       active;
   } note_event_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   pitch_onset_note_trigger_unit u_top (.*);

   always #5 clock = ~clock;

   logic [13:0] note_bounds [0:58] = '{
      340, 360, 381, 404, 428, 453, 480, 509, 539, 571, 605, 641, 679, 719, 762, 807,
      855, 906, 960, 1017, 1078, 1142, 1210, 1281, 1358, 1438, 1524, 1614, 1710, 1812,
      1920, 2034, 2155, 2283, 2419, 2562, 2715, 2876, 3047, 3228, 3420, 3624, 3839,
      4067, 4309, 4565, 4837, 5124, 5429, 5752, 6094, 6456, 6840, 7247, 7678, 8134,
      8618, 9130, 9673};

   // predictor configuration and state
   logic [15:0] cfg [0:7] = '{655, 328, 717, 512, 1440, 20, 150, 1200};
   logic [15:0] p_peak, p_pitch, p_prev, p_onset_peak;
   logic [10:0] p_conf;
   logic        p_capturing, p_sounding;
   logic [31:0] p_window_start, p_last_loud;
   logic [23:0] p_sum;
   logic [7:0]  p_count;

   logic [79:0]     pending_ticks [$];
   note_event_type  expected_events [$];
   logic [31:0]     clock_ms = '0;
   int              send_idle = 0, recv_idle = 0;
   int              n_ticks = 0, n_checked = 0, n_on = 0, n_off = 0, n_errors = 0;
   int              quiet_cycles = 0;

   function automatic logic [6:0] mean_to_note(input logic [23:0] mean);
      int n;
      n = 16;
      for (int i = 0; i < 59; i++)
         if (mean >= note_bounds[i]) n++;
      if (n < 25) n = 25;
      if (n > 108) n = 108;
      return n[6:0];
   endfunction

   function automatic void trigger_predict(input logic [79:0] d);
      logic [31:0] now_v;
      logic [10:0] thr;
      logic [24:0] acc;
      logic [27:0] prod;
      note_event_type r;
      now_v = d[76:45];
      r = '{EV_NONE, 7'd0, 7'd0, 1'b0};
      if (d[0]) p_peak = d[16:1];
      if (d[17]) begin
         p_pitch = d[33:18];
         p_conf = d[44:34];
      end
      if (p_sounding && p_peak > cfg[CSR_QUIET]) p_last_loud = now_v;
      if (!p_sounding && !p_capturing && p_peak > cfg[CSR_ONSET]
          && p_prev <= cfg[CSR_ONSET]) begin
         p_capturing = 1'b1;
         p_window_start = now_v;
         p_onset_peak = p_peak;
         p_sum = '0;
         p_count = '0;
      end
      p_prev = p_peak;
      if (!p_sounding && p_capturing) begin
         thr = (p_pitch < cfg[CSR_SPLIT]) ? cfg[CSR_CONF_LO][10:0] : cfg[CSR_CONF_HI][10:0];
         if (p_conf > thr && p_pitch > 16'd320 && p_pitch < 16'd9600 && p_count < 8'd255) begin
            acc = {1'b0, p_sum} + {9'd0, p_pitch};
            p_sum = acc[24] ? 24'hFFFFFF : acc[23:0];
            p_count++;
         end
         if (now_v - p_window_start >= cfg[CSR_CAPTURE]) begin
            p_capturing = 1'b0;
            if (p_count >= 2) begin
               prod = p_onset_peak * cfg[CSR_GAIN][11:0];
               r.vel = (prod[27:16] < 20) ? 7'd20 : (prod[27:16] > 127) ? 7'd127
                       : prod[22:16];
               r.note = mean_to_note(p_sum / p_count);
               r.ev = EV_NOTE_ON;
               p_sounding = 1'b1;
               p_last_loud = now_v;
            end
         end
      end
      if (p_sounding && now_v - p_last_loud > cfg[CSR_RELEASE]) begin
         p_sounding = 1'b0;
         r = '{EV_NOTE_OFF, 7'd0, 7'd0, 1'b0};
      end
      r.active = p_sounding;
      expected_events.push_back(r);
   endfunction

   task automatic put_tick(input bit pv, input logic [15:0] peak, input bit tv,
                           input logic [15:0] pitch, input logic [10:0] conf,
                           input logic [31:0] dt);
      clock_ms += dt;
      pending_ticks.push_back({3'b0, clock_ms, conf, pitch, tv, peak, pv});
      n_ticks++;
   endtask

   task automatic noise_tick();
      put_tick(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
               16'($urandom), 11'($urandom_range(0, 1024)),
               ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 300));
   endtask

   // well-formed note: quiet, onset, capture window, sustain, release
   task automatic play_note(input int window_ticks);
      int center, step;
      if (cfg[CSR_ONSET] == 16'hFFFF) begin
         noise_tick();
         return;
      end
      put_tick(1, 16'($urandom_range(0, cfg[CSR_ONSET])), 0, 0, 0, $urandom_range(1, 30));
      put_tick(1, 16'($urandom_range(cfg[CSR_ONSET] + 1, 65535)),
               1'($urandom_range(0, 1)), 16'($urandom), 11'($urandom_range(0, 1024)),
               $urandom_range(0, 5));
      center = $urandom_range(330, 9590);
      step = cfg[CSR_CAPTURE] / window_ticks + 1;
      for (int i = 0; i < window_ticks; i++)
         put_tick(1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(0, 5) != 0,
                  16'(center + $urandom_range(0, 20) - 10),
                  11'($urandom_range(500, 1024)),
                  (window_ticks > 50) ? 1 : $urandom_range(1, step));
      repeat ($urandom_range(0, 5))
         put_tick(1, 16'($urandom_range(cfg[CSR_QUIET], 65535)), 1'($urandom_range(0, 1)),
                  16'($urandom), 11'($urandom_range(0, 1024)), $urandom_range(5, 60));
      step = $urandom_range(1, 4);
      repeat (step)
         put_tick(1, 16'($urandom_range(0, cfg[CSR_QUIET])), 1'($urandom_range(0, 1)),
                  16'($urandom), 11'($urandom_range(0, 1024)),
                  cfg[CSR_RELEASE] / step + $urandom_range(1, 20));
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      cfg[idx] = (idx == CSR_CONF_HI || idx == CSR_CONF_LO) ? {5'd0, val[10:0]}
                 : (idx == CSR_GAIN) ? {4'd0, val[11:0]} : val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int items);
      int target;
      target = n_ticks + items;
      while (n_ticks < target)
         if ($urandom_range(0, 99) < 80) play_note($urandom_range(1, 8));
         else noise_tick();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) trigger_predict(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_ticks.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      note_event_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, rsp_tdata);
               n_errors++;
            end else begin
               e = expected_events.pop_front();
               n_checked++;
               if (e.ev == EV_NOTE_ON) n_on++;
               if (e.ev == EV_NOTE_OFF) n_off++;
               if (rsp_tdata[1:0] !== e.ev || rsp_tdata[8:2] !== e.note
                   || rsp_tdata[15:9] !== e.vel || rsp_tdata[16] !== e.active
                   || rsp_tdata[23:17] !== 7'd0) begin
                  $display("%0t: mismatch expected ev=%0d note=%0d vel=%0d act=%0d, ",
                           $time, e.ev, e.note, e.vel, e.active,
                           "actual ev=%0d note=%0d vel=%0d act=%0d",
                           rsp_tdata[1:0], rsp_tdata[8:2], rsp_tdata[15:9],
                           rsp_tdata[16]);
                  n_errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      p_peak = '0; p_pitch = '0; p_prev = '0; p_onset_peak = '0; p_conf = '0;
      p_capturing = 1'b0; p_sounding = 1'b0; p_window_start = '0; p_last_loud = '0;
      p_sum = '0; p_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle = 12;
      recv_idle = 48;
      // directed: field extremes, pitch band edges, split edge, note on and off
      put_tick(1, 16'hFFFF, 1, 16'hFFFF, 11'd1024, 0);
      put_tick(1, 16'h0000, 1, 16'h0000, 11'd0, 32'hFFFF_FFFF);
      put_tick(1, 16'd700, 1, 16'd320, 11'd1024, 1);
      put_tick(0, 0, 1, 16'd321, 11'd1024, 1);
      put_tick(0, 0, 1, 16'd9599, 11'd1024, 1);
      put_tick(0, 0, 1, 16'd9600, 11'd1024, 1);
      put_tick(0, 0, 1, 16'd1440, 11'd717, 1);
      put_tick(0, 0, 1, 16'd1439, 11'd513, 1);
      put_tick(0, 0, 1, 16'd1440, 11'd718, 20);
      put_tick(1, 16'd0, 0, 0, 0, 100);
      put_tick(1, 16'd0, 0, 0, 0, 100);
      put_tick(1, 16'd800, 1, 16'd2000, 11'd1, 1);
      put_tick(0, 0, 0, 0, 0, 30);
      play_note(3);
      random_phase(380);
      wait_drained();
      // mid settings with a long window to saturate the pitch count
      write_csr(CSR_ONSET, 16'd4000);
      write_csr(CSR_QUIET, 16'd2000);
      write_csr(CSR_CONF_HI, 16'd600);
      write_csr(CSR_CONF_LO, 16'd300);
      write_csr(CSR_SPLIT, 16'd3000);
      write_csr(CSR_CAPTURE, 16'd300);
      write_csr(CSR_RELEASE, 16'd500);
      write_csr(CSR_GAIN, 16'd3000);
      play_note(270);
      random_phase(120);
      wait_drained();
      send_idle = 48;
      recv_idle = 12;
      // all-zero settings
      for (int i = 0; i < 8; i++) write_csr(csr_index_type'(i), 16'd0);
      random_phase(400);
      wait_drained();
      send_idle = 0;
      recv_idle = 0;
      // high settings, out-of-range confidence and a time wrap
      write_csr(CSR_ONSET, 16'd1);
      write_csr(CSR_QUIET, 16'hFFFF);
      write_csr(CSR_CONF_HI, 16'd1024);
      write_csr(CSR_CONF_LO, 16'hFFFF);
      write_csr(CSR_SPLIT, 16'hFFFF);
      write_csr(CSR_CAPTURE, 16'hFFFF);
      write_csr(CSR_RELEASE, 16'hFFFF);
      write_csr(CSR_GAIN, 16'hFFFF);
      clock_ms = 32'hFFFF_0000;
      random_phase(60);
      wait_drained();
      write_csr(CSR_CONF_LO, 16'd400);
      write_csr(CSR_CAPTURE, 16'd40);
      write_csr(CSR_RELEASE, 16'd200);
      write_csr(CSR_QUIET, 16'd500);
      write_csr(CSR_ONSET, 16'hFFFF);
      random_phase(30);
      wait_drained();
      write_csr(CSR_ONSET, 16'd1000);
      random_phase(300);
      wait_drained();
      $display("Covered %0d ticks over six register settings: %0d results checked,",
               n_ticks, n_checked);
      $display("%0d note-on and %0d note-off events, %0d errors", n_on, n_off, n_errors);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
src/ponte_pkg.sv
src/ponte_front.sv
src/ponte_fifo.sv
src/ponte_back.sv
src/pitch_onset_note_trigger_unit.sv
tb/tb.sv
